>>> rtl/core/sirs_pkg.sv
// Shared types, constants and helpers for the signed integer to radix symbol block.
// No dependencies; every module of the block imports this package.
package sirs_pkg;

  // Alphabet limits
  localparam int MAX_RADIX      = 16;
  localparam int STORED_SYMBOLS = 16;
  localparam int DIGIT_W        = $clog2(MAX_RADIX);
  localparam int RADIX_W        = 5;
  localparam int VALUE_W        = 32;
  localparam int SYM_W          = 8;
  localparam int MAX_DIGITS     = VALUE_W;
  localparam int CNT_W          = $clog2(MAX_DIGITS + 1);
  localparam int STK_IDX_W      = $clog2(MAX_DIGITS);

  // Front-to-back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Divider: dividend bits retired per cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_ITERS = VALUE_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  // Special symbols
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_HI  = 2'd2;

  // One classified item on its way to the back end
  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic               neg;
    logic               zero;
  } entry_t;

  // Divider result
  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quo;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_SIGN,
    ST_EMIT,
    ST_ZERO
  } back_state_t;

  // Pick alphabet symbol idx out of the packed alphabet
  function automatic logic [SYM_W-1:0] sym_at(
    input logic [STORED_SYMBOLS*SYM_W-1:0] syms,
    input logic [DIGIT_W-1:0]              idx
  );
    sym_at = syms[idx*SYM_W +: SYM_W];
  endfunction

endpackage

>>> rtl/core/sirs_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on sirs_pkg.
module sirs_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [sirs_pkg::VALUE_W-1:0] in_value,
  input  logic                                alph_ok,
  input  logic                                q_pop,
  output logic                                q_empty,
  output sirs_pkg::entry_t                    q_data
);
  import sirs_pkg::*;

  entry_t               q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 accept;
  logic                 q_push;
  entry_t               entry;

  // Classify the incoming item
  always_comb begin
    entry.neg  = in_value[VALUE_W-1];
    entry.mag  = entry.neg ? (~in_value + 1'b1) : in_value;
    entry.zero = (in_value == '0);
  end

  assign in_full = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_empty = (count_r == '0);
  assign accept  = in_push && !in_full;
  // Drop items while the alphabet is unusable
  assign q_push  = accept && alph_ok;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold queued items
  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

  assign q_data = q_mem_r[rd_ptr_r];

endmodule

>>> rtl/core/sirs_divider.sv
// Iterative divider: splits a 32-bit magnitude by the radix, eight dividend bits a cycle.
// Depends on sirs_pkg.
module sirs_divider (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [sirs_pkg::VALUE_W-1:0]     dividend,
  input  logic [sirs_pkg::RADIX_W-1:0]     divisor,
  output sirs_pkg::div_res_t               res
);
  import sirs_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [VALUE_W-1:0]   work_r, work_nxt;
  logic [DIGIT_W-1:0]   rem_r, rem_nxt;

  // Restoring division over the top DIV_BITS bits of the working word
  always_comb begin
    logic [DIGIT_W-1:0]  rem;
    logic [DIGIT_W:0]    trial;
    logic [DIV_BITS-1:0] qbits;
    rem   = rem_r;
    qbits = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem, work_r[VALUE_W-1-i]};
      if (trial >= (DIGIT_W+1)'(divisor)) begin
        rem                  = DIGIT_W'(trial - (DIGIT_W+1)'(divisor));
        qbits[DIV_BITS-1-i]  = 1'b1;
      end else begin
        rem = DIGIT_W'(trial);
      end
    end
    rem_nxt  = rem;
    work_nxt = {work_r[VALUE_W-DIV_BITS-1:0], qbits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == DIV_CNT_W'(DIV_ITERS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_ITERS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Load on start, shift quotient bits in while busy
  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= dividend;
      rem_r  <= '0;
    end else if (busy_r) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign res.done = done_r;
  assign res.quo  = work_r;
  assign res.rem  = rem_r;

endmodule

>>> rtl/core/sirs_back.sv
// Back end: converts queued magnitudes to digits, stacks them and emits symbols MSB first.
// Depends on sirs_pkg and sirs_divider.
module sirs_back (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            q_empty,
  input  sirs_pkg::entry_t                                q_data,
  output logic                                            q_pop,
  input  logic [sirs_pkg::RADIX_W-1:0]                    radix,
  input  logic [sirs_pkg::STORED_SYMBOLS*sirs_pkg::SYM_W-1:0] symbols,
  output logic                                            out_empty,
  input  logic                                            out_pop,
  output logic [sirs_pkg::SYM_W-1:0]                      out_symbol,
  output logic                                            out_last
);
  import sirs_pkg::*;

  back_state_t         state_r, state_nxt;
  logic [VALUE_W-1:0]  mag_r;
  logic                neg_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DIGIT_W-1:0]  stack_r [MAX_DIGITS];
  logic                out_valid_r;
  logic [SYM_W-1:0]    out_sym_r, out_sym_nxt;
  logic                out_last_r, out_last_nxt;
  logic                slot_free;
  logic                div_start;
  logic                push_digit;
  logic                out_load;
  logic [STK_IDX_W-1:0] top_idx;
  div_res_t            div_res;

  sirs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_r),
    .divisor  (radix),
    .res      (div_res)
  );

  assign slot_free = !out_valid_r || out_pop;
  assign top_idx   = STK_IDX_W'(cnt_r - 1'b1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_data.zero ? ST_ZERO : ST_LOAD;
        end
      end
      ST_LOAD: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_res.done) begin
          if (div_res.quo != '0) begin
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = neg_r ? ST_SIGN : ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free && (cnt_r == CNT_W'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_pop        = 1'b0;
    div_start    = 1'b0;
    push_digit   = 1'b0;
    out_load     = 1'b0;
    out_sym_nxt  = SYM_ZERO;
    out_last_nxt = 1'b1;
    unique case (state_r)
      ST_IDLE: q_pop = !q_empty;
      ST_LOAD: div_start = 1'b1;
      ST_WAIT: push_digit = div_res.done;
      ST_SIGN: begin
        out_load     = slot_free;
        out_sym_nxt  = SYM_MINUS;
        out_last_nxt = 1'b0;
      end
      ST_EMIT: begin
        out_load     = slot_free;
        out_sym_nxt  = sym_at(symbols, stack_r[top_idx]);
        out_last_nxt = (cnt_r == CNT_W'(1));
      end
      ST_ZERO: begin
        out_load     = slot_free;
        out_sym_nxt  = SYM_ZERO;
        out_last_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        cnt_r <= '0;
      end else if (push_digit) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (out_load && (state_r == ST_EMIT)) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: magnitude, sign, digit stack and output register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      mag_r <= q_data.mag;
      neg_r <= q_data.neg;
    end else if (push_digit) begin
      mag_r <= div_res.quo;
    end
    if (push_digit) begin
      stack_r[cnt_r[STK_IDX_W-1:0]] <= div_res.rem;
    end
    if (out_load) begin
      out_sym_r  <= out_sym_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_empty  = !out_valid_r;
  assign out_symbol = out_sym_r;
  assign out_last   = out_last_r;

endmodule

>>> rtl/core/signed_int_to_radix_symbols.sv
// Signed integer to radix symbols: top level with configuration registers and alphabet check.
// Sequencing: each digit passes through the divider as a load, four 8-bit division steps and a
// digit store, and the sign or first digit is out once every digit is stacked. The back end
// takes the next queued item only after the last symbol of the current one; meanwhile the
// two-entry queue keeps taking items. Items pushed while the alphabet is bad are dropped.
// Reset: synchronous active-low rst_n clears queue, sequencer, output slot and registers.
module signed_int_to_radix_symbols (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [sirs_pkg::VALUE_W-1:0] in_value,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [sirs_pkg::SYM_W-1:0]          out_symbol,
  output logic                                out_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sirs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                         cfg_data
);
  import sirs_pkg::*;

  logic [RADIX_W-1:0]              radix_r;
  logic [63:0]                     sym_low_r;
  logic [63:0]                     sym_high_r;
  logic [STORED_SYMBOLS*SYM_W-1:0] symbols;
  logic                            alph_ok;
  logic                            q_pop;
  logic                            q_empty;
  entry_t                          q_data;

  assign cfg_ready = 1'b1;
  assign symbols   = {sym_high_r, sym_low_r};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= '0;
      sym_low_r  <= '0;
      sym_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIX:   radix_r    <= cfg_data[RADIX_W-1:0];
        CFG_SYM_LOW: sym_low_r  <= cfg_data;
        CFG_SYM_HI:  sym_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Check the alphabet: size range, no sign symbols, no duplicates
  always_comb begin
    logic bad;
    bad = (radix_r < RADIX_W'(2)) || (radix_r > RADIX_W'(MAX_RADIX)) ||
          (radix_r > RADIX_W'(STORED_SYMBOLS));
    for (int i = 0; i < STORED_SYMBOLS; i++) begin
      if (RADIX_W'(i) < radix_r) begin
        if ((symbols[i*SYM_W +: SYM_W] == SYM_PLUS) ||
            (symbols[i*SYM_W +: SYM_W] == SYM_MINUS)) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < STORED_SYMBOLS; j++) begin
          if ((RADIX_W'(j) < radix_r) &&
              (symbols[i*SYM_W +: SYM_W] == symbols[j*SYM_W +: SYM_W])) begin
            bad = 1'b1;
          end
        end
      end
    end
    alph_ok = !bad;
  end

  sirs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_value (in_value),
    .alph_ok  (alph_ok),
    .q_pop    (q_pop),
    .q_empty  (q_empty),
    .q_data   (q_data)
  );

  sirs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .radix      (radix_r),
    .symbols    (symbols),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_symbol (out_symbol),
    .out_last   (out_last)
  );

`ifndef SYNTH
  // Back end never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // A sign symbol never closes a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_symbol == SYM_MINUS)) |-> !out_last)
    else $error("sign symbol flagged last");

  // A plus symbol can never be emitted
  a_no_plus: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_symbol != SYM_PLUS))
    else $error("plus symbol emitted");
`endif

endmodule
